FILE: hw/rtl/portable_filename_checker_defines.svh
// ----------------------------------------------------------------------------
// Portable file name checker: assertion macros
// Shared macros for the concurrent checks on the checker's ports.
// ----------------------------------------------------------------------------
`ifndef PORTABLE_FILENAME_CHECKER_DEFINES_SVH
`define PORTABLE_FILENAME_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfc check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfc check failed: next-cycle implication");

`endif

FILE: hw/rtl/pfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Constants and types shared by the portable file name checker modules.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int MAX_NAME_BYTES = 255;
  localparam int STEM_KEEP      = 8;

  // Byte counter saturates at MAX_NAME_BYTES + 1.
  localparam int CNT_W      = $clog2(MAX_NAME_BYTES + 2);
  // Stem lengths run up to STEM_KEEP + 1.
  localparam int STEM_LEN_W = $clog2(STEM_KEEP + 2);
  localparam int STEM_IDX_W = $clog2(STEM_KEEP);
  localparam int CP_W       = 21;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef logic [7:0] pfc_octet_t;

  // Per-transfer control sent from the top level to the state keepers.
  typedef struct packed {
    logic take;   // a byte is consumed this cycle
    logic clear;  // the name ends this cycle; state returns to empty
  } pfc_ctrl_t;

endpackage

FILE: hw/rtl/pfc_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_utf8
// UTF-8 decoder, character screen, length counter and last-byte tracking.
// ----------------------------------------------------------------------------
module pfc_utf8 (
  input  logic                clk,
  input  logic                rst_n,
  input  pfc_pkg::pfc_ctrl_t  ctrl,
  input  pfc_pkg::pfc_octet_t byte_in,
  output logic                name_ok
);
  import pfc_pkg::*;

  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_2B   = 2'd1;
  localparam logic [1:0] SEQ_3B   = 2'd2;
  localparam logic [1:0] SEQ_4B   = 2'd3;

  localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

  logic [CNT_W-1:0] count_r, count_nxt, count_upd;
  logic [1:0]       pend_r, pend_nxt, pend_upd;
  logic [CP_W-1:0]  cp_r, cp_nxt, cp_upd, cp_shift, cp_low;
  logic [1:0]       cls_r, cls_nxt, cls_upd;
  logic             failed_r, failed_nxt, failed_upd;
  pfc_octet_t       prev_r, prev_nxt, prev_upd;

  function automatic logic forbidden(input pfc_octet_t b);
    return (b < 8'h20) || (b == 8'h7F) || (b == "<") || (b == ">") || (b == ":") ||
           (b == "\"") || (b == "/") || (b == "\\") || (b == "|") || (b == "?") ||
           (b == "*");
  endfunction

  assign cp_shift = {cp_r[CP_W-7:0], byte_in[5:0]};

  always_comb begin
    unique case (cls_r)
      SEQ_2B:  cp_low = 21'h000080;
      SEQ_3B:  cp_low = 21'h000800;
      default: cp_low = 21'h010000;
    endcase
  end

  always_comb begin
    count_upd  = count_r;
    pend_upd   = pend_r;
    cp_upd     = cp_r;
    cls_upd    = cls_r;
    failed_upd = failed_r;
    prev_upd   = prev_r;
    if (ctrl.take) begin
      if (count_r <= CNT_W'(MAX_NAME_BYTES)) begin
        count_upd = count_r + 1'b1;
      end
      prev_upd = byte_in;
      if (pend_r != 2'd0) begin
        if (byte_in[7:6] != 2'b10) begin
          failed_upd = 1'b1;
          pend_upd   = 2'd0;
        end else begin
          cp_upd   = cp_shift;
          pend_upd = pend_r - 2'd1;
          if (pend_r == 2'd1) begin
            if ((cp_shift < cp_low) || (cp_shift > CP_MAX) ||
                ((cp_shift >= SURR_LO) && (cp_shift <= SURR_HI))) begin
              failed_upd = 1'b1;
            end
          end
        end
      end else if (!byte_in[7]) begin
        if (forbidden(byte_in)) begin
          failed_upd = 1'b1;
        end
      end else if (byte_in[7:5] == 3'b110) begin
        cp_upd   = CP_W'(byte_in[4:0]);
        pend_upd = 2'd1;
        cls_upd  = SEQ_2B;
      end else if (byte_in[7:4] == 4'b1110) begin
        cp_upd   = CP_W'(byte_in[3:0]);
        pend_upd = 2'd2;
        cls_upd  = SEQ_3B;
      end else if (byte_in[7:3] == 5'b11110) begin
        cp_upd   = CP_W'(byte_in[2:0]);
        pend_upd = 2'd3;
        cls_upd  = SEQ_4B;
      end else begin
        failed_upd = 1'b1;
      end
    end
  end

  // Verdict on the state as it stands once this byte is taken.
  assign name_ok = !failed_upd && (count_upd != '0) &&
                   (count_upd <= CNT_W'(MAX_NAME_BYTES)) &&
                   (prev_upd != CH_SPACE) && (prev_upd != CH_DOT) &&
                   (pend_upd == 2'd0);

  always_comb begin
    if (ctrl.clear) begin
      count_nxt  = '0;
      pend_nxt   = 2'd0;
      cp_nxt     = '0;
      cls_nxt    = SEQ_NONE;
      failed_nxt = 1'b0;
      prev_nxt   = '0;
    end else begin
      count_nxt  = count_upd;
      pend_nxt   = pend_upd;
      cp_nxt     = cp_upd;
      cls_nxt    = cls_upd;
      failed_nxt = failed_upd;
      prev_nxt   = prev_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      pend_r   <= 2'd0;
      cp_r     <= '0;
      cls_r    <= SEQ_NONE;
      failed_r <= 1'b0;
      prev_r   <= '0;
    end else begin
      count_r  <= count_nxt;
      pend_r   <= pend_nxt;
      cp_r     <= cp_nxt;
      cls_r    <= cls_nxt;
      failed_r <= failed_nxt;
      prev_r   <= prev_nxt;
    end
  end

endmodule

FILE: hw/rtl/pfc_stem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_stem
// Stem capture and reserved device name match.
// ----------------------------------------------------------------------------
module pfc_stem (
  input  logic                clk,
  input  logic                rst_n,
  input  pfc_pkg::pfc_ctrl_t  ctrl,
  input  pfc_pkg::pfc_octet_t byte_in,
  output logic                reserved
);
  import pfc_pkg::*;

  localparam logic [23:0] W_CON    = "CON";
  localparam logic [23:0] W_PRN    = "PRN";
  localparam logic [23:0] W_AUX    = "AUX";
  localparam logic [23:0] W_NUL    = "NUL";
  localparam logic [23:0] W_COM    = "COM";
  localparam logic [23:0] W_LPT    = "LPT";
  localparam logic [47:0] W_CONIN  = "CONIN$";
  localparam logic [55:0] W_CONOUT = "CONOUT$";

  logic                  closed_r, closed_nxt, closed_upd;
  logic [STEM_LEN_W-1:0] len_r, len_nxt, len_upd;
  logic [STEM_LEN_W-1:0] trim_r, trim_nxt, trim_upd;
  pfc_octet_t            bytes_r   [STEM_KEEP];
  pfc_octet_t            bytes_upd [STEM_KEEP];
  pfc_octet_t            up        [STEM_KEEP];
  logic                  stem_byte, room, wr_en;
  logic [23:0]           pre3;
  logic                  len3, len4, len5, len6, len7, suffix_ok;

  function automatic pfc_octet_t upcase(input pfc_octet_t c);
    return ((c >= "a") && (c <= "z")) ? (c - 8'h20) : c;
  endfunction

  assign stem_byte = ctrl.take && !closed_r && (byte_in != CH_DOT);
  assign room      = len_r < STEM_LEN_W'(STEM_KEEP);
  assign wr_en     = stem_byte && room;

  always_comb begin
    closed_upd = closed_r || (ctrl.take && (byte_in == CH_DOT));
    len_upd    = wr_en ? (len_r + 1'b1) : len_r;
    trim_upd   = trim_r;
    if (stem_byte && (byte_in != CH_SPACE)) begin
      trim_upd = room ? (len_r + 1'b1) : STEM_LEN_W'(STEM_KEEP + 1);
    end
  end

  // Stem contents as they stand after this byte, folded to upper case.
  always_comb begin
    for (int i = 0; i < STEM_KEEP; i++) begin
      bytes_upd[i] = (wr_en && (len_r[STEM_IDX_W-1:0] == STEM_IDX_W'(i))) ?
                     byte_in : bytes_r[i];
      up[i]        = upcase(bytes_upd[i]);
    end
  end

  assign pre3 = {up[0], up[1], up[2]};
  assign len3 = trim_upd == STEM_LEN_W'(3);
  assign len4 = trim_upd == STEM_LEN_W'(4);
  assign len5 = trim_upd == STEM_LEN_W'(5);
  assign len6 = trim_upd == STEM_LEN_W'(6);
  assign len7 = trim_upd == STEM_LEN_W'(7);

  // A digit, or the two-byte UTF-8 form of superscript one, two or three.
  assign suffix_ok = len4 ? ((bytes_upd[3] >= "0") && (bytes_upd[3] <= "9")) :
                     ((bytes_upd[3] == 8'hC2) &&
                      ((bytes_upd[4] == 8'hB9) || (bytes_upd[4] == 8'hB2) ||
                       (bytes_upd[4] == 8'hB3)));

  assign reserved =
    (len3 && ((pre3 == W_CON) || (pre3 == W_PRN) || (pre3 == W_AUX) || (pre3 == W_NUL))) ||
    (len6 && ({up[0], up[1], up[2], up[3], up[4], up[5]} == W_CONIN)) ||
    (len7 && ({up[0], up[1], up[2], up[3], up[4], up[5], up[6]} == W_CONOUT)) ||
    ((len4 || len5) && ((pre3 == W_COM) || (pre3 == W_LPT)) && suffix_ok);

  always_comb begin
    if (ctrl.clear) begin
      closed_nxt = 1'b0;
      len_nxt    = '0;
      trim_nxt   = '0;
    end else begin
      closed_nxt = closed_upd;
      len_nxt    = len_upd;
      trim_nxt   = trim_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r <= 1'b0;
      len_r    <= '0;
      trim_r   <= '0;
    end else begin
      closed_r <= closed_nxt;
      len_r    <= len_nxt;
      trim_r   <= trim_nxt;
    end
  end

  // Stem bytes are only read below the current length, so they need no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bytes_r[len_r[STEM_IDX_W-1:0]] <= byte_in;
    end
  end

endmodule

FILE: hw/rtl/portable_filename_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// portable_filename_checker
// Streams a file name byte by byte and reports whether it is portable.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_byte_in, in_has_byte, in_last
//   out_     output     out_valid / out_ready  out_portable
//
// One input transfer is taken per cycle while in_ready is high; the per-name
// state is updated and the verdict registered on that same transfer edge.
// A transfer with in_last set yields one result, valid from the next cycle.
// The single output register decouples the sides: input is taken whenever
// the register is empty or its result is taken in the same cycle.
// Reset (rst_n low, synchronous) empties the output and the per-name state.
//
// The name is judged on four counts: length within 1..MAX_NAME_BYTES, no
// trailing space or dot, valid UTF-8 free of control and reserved punctuation
// characters, and a stem that is not a reserved device name. The decoder
// (pfc_utf8) and the stem tracker (pfc_stem) each hold their own state and
// give a flag computed on the state as it stands after the current byte, so
// a byte on the final transfer is taken before the verdict.
// ----------------------------------------------------------------------------
module portable_filename_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfc_pkg::pfc_octet_t in_byte_in,
  input  logic                in_has_byte,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_portable
);
  import pfc_pkg::*;

  pfc_ctrl_t ctrl;
  logic      in_xfer;
  logic      name_ok, reserved;
  logic      out_valid_r, out_valid_nxt;
  logic      portable_r, portable_nxt;

  // The output register can be refilled in the cycle its result leaves.
  assign in_ready   = !out_valid_r || out_ready;
  assign in_xfer    = in_valid && in_ready;
  assign ctrl.take  = in_xfer && in_has_byte;
  assign ctrl.clear = in_xfer && in_last;

  pfc_utf8 u_utf8 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .byte_in (in_byte_in),
    .name_ok (name_ok)
  );

  pfc_stem u_stem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .byte_in  (in_byte_in),
    .reserved (reserved)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    portable_nxt  = portable_r;
    if (ctrl.clear) begin
      out_valid_nxt = 1'b1;
      portable_nxt  = name_ok && !reserved;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: loaded only alongside a new result.
  always_ff @(posedge clk) begin
    portable_r <= portable_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_portable = portable_r;

endmodule

FILE: hw/rtl/pfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks on the portable file name checker, bound to the top.
// ----------------------------------------------------------------------------
`include "portable_filename_checker_defines.svh"

module pfc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_portable
);

  // The output register is empty on the first cycle out of reset.
  `PFC_ASSERT_IMPL(a_reset_empties, clk, rst_n, !$past(rst_n), !out_valid)

  // With no result pending the block always takes input.
  `PFC_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

  // A new result only follows a transfer that ends a name.
  `PFC_ASSERT_IMPL(a_result_from_last, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready && in_last))

  // A transfer inside a name never produces a result on its own.
  `PFC_ASSERT_NEXT(a_no_spurious_result, clk, rst_n, in_valid && in_ready && !in_last && !out_valid, !out_valid)

  // A stalled result holds its verdict.
  `PFC_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_portable))

endmodule

bind portable_filename_checker pfc_checker u_pfc_checker (.*);
